@@ hw/rtl/dbrp_pkg.sv @@
// Shared types and codes for the record stream parser.
// No dependencies; imported by every module of the block.
package dbrp_pkg;

  localparam int unsigned ColDepth   = 16;
  localparam int unsigned ColIdxW    = 4;
  localparam int unsigned ColTotW    = 5;
  localparam int unsigned DefMaxCols = 16;
  localparam int unsigned DefMaxPay  = 65536;

  localparam logic [1:0] KIND_NULL = 2'd0;
  localparam logic [1:0] KIND_INT  = 2'd1;
  localparam logic [1:0] KIND_TEXT = 2'd2;
  localparam logic [1:0] KIND_BLOB = 2'd3;

  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_HEADER    = 3'd1;
  localparam logic [2:0] ERR_SERIAL    = 3'd2;
  localparam logic [2:0] ERR_TRUNC     = 3'd3;
  localparam logic [2:0] ERR_FLOAT     = 3'd4;
  localparam logic [2:0] ERR_TOO_MANY  = 3'd5;

  typedef enum logic [2:0] {
    CLS_NULL  = 3'd0,
    CLS_INT   = 3'd1,
    CLS_ZERO  = 3'd2,
    CLS_ONE   = 3'd3,
    CLS_TEXT  = 3'd4,
    CLS_BLOB  = 3'd5,
    CLS_FLOAT = 3'd6,
    CLS_RSVD  = 3'd7
  } cls_e;

  typedef struct packed {
    logic [ColIdxW-1:0] column;
    logic [1:0]         kind;
    logic signed [63:0] int_value;
    logic [7:0]         data_byte;
    logic               byte_valid;
    logic               value_done;
    logic               record_done;
    logic [2:0]         error_code;
  } result_t;

endpackage

@@ hw/rtl/db_record_stream_parser_top.sv @@
// Channel    Dir  Handshake               Payload
// in         in   in_valid_i/in_ready_o   payload_byte_i, last_byte_i
// out        out  out_valid_o/out_ready_i column_o .. error_code_o
//
// One payload byte a cycle through an input register into the decoder, when it
// does not stall; a result leaves through the registered result buffer.
// After the header and after each finished value that is not the last, the
// column walk visits every column it reaches (zero-length result, truncation or
// reserved-type error, or start of the next body), input held off. A text or blob
// body cut short by the last byte gives its error result after the byte's result.
// Results pass through a two-entry buffer; the decoder stalls while it is full.
// Reset returns to the start of a record.
// Depends on dbrp_pkg, dbrp_core, dbrp_coltab and dbrp_out_fifo.
module db_record_stream_parser_top import dbrp_pkg::*; #(
  parameter int unsigned MAX_COLUMNS       = DefMaxCols,
  parameter int unsigned MAX_PAYLOAD_BYTES = DefMaxPay
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         payload_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         column_o,
  output logic [1:0]         kind_o,
  output logic signed [63:0] int_value_o,
  output logic [7:0]         data_byte_o,
  output logic               byte_valid_o,
  output logic               value_done_o,
  output logic               record_done_o,
  output logic [2:0]         error_code_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       take, full, push;
  result_t    res, res_out;

  assign in_ready_o = ~in_vld_q | take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      in_byte_q <= payload_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  dbrp_core #(
    .MAX_COLUMNS       (MAX_COLUMNS),
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_core (
    .clk_i,
    .rst_ni,
    .in_vld_i  (in_vld_q),
    .in_byte_i (in_byte_q),
    .in_last_i (in_last_q),
    .take_o    (take),
    .full_i    (full),
    .push_o    (push),
    .res_o     (res)
  );

  dbrp_out_fifo u_out (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (res),
    .full_o  (full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (res_out)
  );

  assign column_o      = res_out.column;
  assign kind_o        = res_out.kind;
  assign int_value_o   = res_out.int_value;
  assign data_byte_o   = res_out.data_byte;
  assign byte_valid_o  = res_out.byte_valid;
  assign value_done_o  = res_out.value_done;
  assign record_done_o = res_out.record_done;
  assign error_code_o  = res_out.error_code;

  a_err_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o != ERR_OK) |-> (record_done_o && !value_done_o))
    else $error("error result does not close the record");

  a_byte_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_valid_o) |-> (kind_o == KIND_TEXT || kind_o == KIND_BLOB))
    else $error("data byte on a non-text, non-blob result");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("result pushed into a full buffer");

  a_take_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> in_vld_q)
    else $error("decoder consumed an empty input register");

endmodule

@@ hw/rtl/dbrp_coltab.sv @@
// Column table: one entry per column, class and body length.
// Depends on dbrp_pkg.
module dbrp_coltab import dbrp_pkg::*; #(
  parameter int unsigned Width = 20
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ColIdxW-1:0]   waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [ColIdxW-1:0]   raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem_q [ColDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[raddr_i];

endmodule

@@ hw/rtl/dbrp_out_fifo.sv @@
// Two-entry result buffer between the decoder and the output channel.
// Depends on dbrp_pkg.
module dbrp_out_fifo import dbrp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    full_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

endmodule

@@ hw/rtl/dbrp_core.sv @@
// Record decoder: header varints, column walk and value bodies; at most one result
// a cycle. Depends on dbrp_pkg and dbrp_coltab.
module dbrp_core import dbrp_pkg::*; #(
  parameter int unsigned MAX_COLUMNS       = DefMaxCols,
  parameter int unsigned MAX_PAYLOAD_BYTES = DefMaxPay
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_vld_i,
  input  logic [7:0] in_byte_i,
  input  logic    in_last_i,
  output logic    take_o,
  input  logic    full_i,
  output logic    push_o,
  output result_t res_o
);

  localparam int unsigned PosW     = $clog2(MAX_PAYLOAD_BYTES + 2);
  localparam int unsigned EntW     = 3 + PosW;
  localparam int unsigned ColLimit = (MAX_COLUMNS < ColDepth) ? MAX_COLUMNS : ColDepth;
  localparam logic [63:0] MaxP64   = 64'(MAX_PAYLOAD_BYTES);
  localparam logic [PosW:0] MaxPW  = (PosW + 1)'(MAX_PAYLOAD_BYTES);
  localparam logic [ColTotW-1:0] LimitW = ColTotW'(ColLimit);

  typedef enum logic [3:0] {
    PH_HSIZE  = 4'b0001,
    PH_SERIAL = 4'b0010,
    PH_VALUE  = 4'b0100,
    PH_WAIT   = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    M_RUN  = 3'b001,
    M_ADV  = 3'b010,
    M_FAIL = 3'b100
  } mode_e;

  phase_e phase_q, phase_d;
  mode_e  mode_q, mode_d;
  logic [PosW-1:0]    bp_q, bp_d, hl_q, hl_d, left_q, left_d;
  logic [63:0]        vacc_q, vacc_d, iacc_q, iacc_d;
  logic [3:0]         vcnt_q, vcnt_d;
  logic [ColTotW-1:0] total_q, total_d;
  logic [ColIdxW-1:0] col_q, col_d;
  logic               ended_q, ended_d;

  logic               tab_we;
  logic [EntW-1:0]    tab_wdata, tab_rdata;
  cls_e               rd_cls;
  logic [PosW-1:0]    rd_size;

  dbrp_coltab #(.Width(EntW)) u_coltab (
    .clk_i,
    .we_i    (tab_we),
    .waddr_i (total_q[ColIdxW-1:0]),
    .wdata_i (tab_wdata),
    .raddr_i (col_q),
    .rdata_o (tab_rdata)
  );

  assign rd_cls  = cls_e'(tab_rdata[EntW-1 -: 3]);
  assign rd_size = tab_rdata[PosW-1:0];

  always_comb begin
    logic [7:0]         b;
    logic               last;
    logic [PosW-1:0]    bp_inc;
    logic [63:0]        vnew;
    logic               vdone;
    logic               do_fin, fin_end;
    logic               quiet;
    logic               last_col;
    logic [PosW-1:0]    bl_new;
    logic [63:0]        acc, sx, len;
    cls_e               ncls;
    logic [PosW-1:0]    nsize;

    b       = in_byte_i;
    last    = in_last_i;
    bp_inc  = bp_q + PosW'(1);
    vnew    = (vcnt_q < 4'd8) ? {vacc_q[56:0], b[6:0]} : {vacc_q[55:0], b};
    vdone   = (vcnt_q < 4'd8) ? ~b[7] : 1'b1;
    last_col = ({1'b0, col_q} + ColTotW'(1)) >= total_q;
    bl_new  = left_q - PosW'(1);
    acc     = {iacc_q[55:0], b};
    do_fin  = 1'b0;
    fin_end = 1'b0;
    quiet   = 1'b0;

    // classify the serial type just completed
    len   = (vnew >> 1) - 64'd6;
    ncls  = CLS_RSVD;
    nsize = '0;
    if (vnew == 64'd0) begin
      ncls = CLS_NULL;
    end else if (vnew <= 64'd4) begin
      ncls = CLS_INT; nsize = PosW'(vnew[2:0]);
    end else if (vnew == 64'd5) begin
      ncls = CLS_INT; nsize = PosW'(6);
    end else if (vnew == 64'd6) begin
      ncls = CLS_INT; nsize = PosW'(8);
    end else if (vnew == 64'd7) begin
      ncls = CLS_FLOAT; nsize = PosW'(8);
    end else if (vnew == 64'd8) begin
      ncls = CLS_ZERO;
    end else if (vnew == 64'd9) begin
      ncls = CLS_ONE;
    end else if (vnew >= 64'd12) begin
      ncls  = vnew[0] ? CLS_TEXT : CLS_BLOB;
      nsize = (len > MaxP64) ? (PosW'(MAX_PAYLOAD_BYTES) + PosW'(1)) : len[PosW-1:0];
    end
    tab_wdata = {ncls, nsize};
    tab_we    = 1'b0;

    // sign-extend the finished integer
    case (rd_size[3:0])
      4'd1:    sx = {{56{acc[7]}}, acc[7:0]};
      4'd2:    sx = {{48{acc[15]}}, acc[15:0]};
      4'd3:    sx = {{40{acc[23]}}, acc[23:0]};
      4'd4:    sx = {{32{acc[31]}}, acc[31:0]};
      4'd6:    sx = {{16{acc[47]}}, acc[47:0]};
      default: sx = acc;
    endcase

    phase_d = phase_q; mode_d = mode_q; bp_d = bp_q; hl_d = hl_q; left_d = left_q;
    vacc_d = vacc_q; iacc_d = iacc_q; vcnt_d = vcnt_q; total_d = total_q;
    col_d = col_q; ended_d = ended_q;
    push_o = 1'b0;
    res_o  = '0;
    take_o = 1'b0;

    if (!full_i) begin
      case (mode_q)
        M_RUN: begin
          if (in_vld_i) begin
            take_o = 1'b1;
            case (phase_q)
              PH_HSIZE: begin
                bp_d = bp_inc;
                if (!vdone) begin
                  vacc_d = vnew;
                  vcnt_d = vcnt_q + 4'd1;
                  if (last) begin
                    res_o.error_code = ERR_HEADER; do_fin = 1'b1; fin_end = 1'b1;
                  end
                end else begin
                  vacc_d = '0;
                  vcnt_d = '0;
                  if (vnew < 64'(bp_inc) || vnew > MaxP64 || (last && vnew > 64'(bp_inc))) begin
                    res_o.error_code = ERR_HEADER; do_fin = 1'b1; fin_end = last;
                  end else begin
                    hl_d  = vnew[PosW-1:0];
                    col_d = '0;
                    if (vnew == 64'(bp_inc)) begin
                      // no columns: a single empty closing result
                      push_o = 1'b1; res_o.record_done = 1'b1;
                      do_fin = 1'b1; fin_end = last;
                    end else begin
                      phase_d = PH_SERIAL;
                    end
                  end
                end
              end
              PH_SERIAL: begin
                bp_d   = bp_inc;
                vacc_d = vnew;
                vcnt_d = vcnt_q + 4'd1;
                if (last && bp_inc < hl_q) begin
                  res_o.error_code = ERR_HEADER; do_fin = 1'b1; fin_end = 1'b1;
                end else if (vdone && total_q >= LimitW) begin
                  res_o.error_code = ERR_TOO_MANY; do_fin = 1'b1; fin_end = last;
                end else begin
                  if (vdone) begin
                    tab_we  = 1'b1;
                    total_d = total_q + ColTotW'(1);
                    vacc_d  = '0;
                    vcnt_d  = '0;
                  end
                  if (bp_inc >= hl_q) begin
                    if (!vdone) begin
                      res_o.error_code = ERR_SERIAL; do_fin = 1'b1; fin_end = last;
                    end else begin
                      col_d = '0; mode_d = M_ADV; ended_d = last; phase_d = PH_VALUE;
                    end
                  end
                end
              end
              PH_VALUE: begin
                bp_d   = bp_inc;
                left_d = bl_new;
                res_o.column = col_q;
                case (rd_cls)
                  CLS_INT: begin
                    iacc_d = acc;
                    if (bl_new == '0) begin
                      push_o = 1'b1;
                      res_o.kind = KIND_INT; res_o.int_value = sx;
                      res_o.value_done = 1'b1; res_o.record_done = last_col;
                      if (last_col) begin
                        do_fin = 1'b1; fin_end = last;
                      end else begin
                        col_d = col_q + ColIdxW'(1); mode_d = M_ADV; ended_d = last;
                      end
                    end else if (last) begin
                      res_o.error_code = ERR_TRUNC; do_fin = 1'b1; fin_end = 1'b1;
                    end
                  end
                  CLS_FLOAT: begin
                    if (bl_new == '0) begin
                      res_o.error_code = ERR_FLOAT; do_fin = 1'b1; fin_end = last;
                    end else if (last) begin
                      res_o.error_code = ERR_TRUNC; do_fin = 1'b1; fin_end = 1'b1;
                    end
                  end
                  default: begin
                    push_o = 1'b1;
                    res_o.kind = (rd_cls == CLS_TEXT) ? KIND_TEXT : KIND_BLOB;
                    res_o.data_byte = b; res_o.byte_valid = 1'b1;
                    if (bl_new == '0) begin
                      res_o.value_done = 1'b1; res_o.record_done = last_col;
                      if (last_col) begin
                        do_fin = 1'b1; fin_end = last;
                      end else begin
                        col_d = col_q + ColIdxW'(1); mode_d = M_ADV; ended_d = last;
                      end
                    end else if (last) begin
                      // byte stands, error follows from the fail mode
                      mode_d = M_FAIL;
                    end
                  end
                endcase
              end
              default: begin
                // drop trailing bytes silently up to the last one
                if (last) begin
                  do_fin = 1'b1; fin_end = 1'b1; quiet = 1'b1;
                end
              end
            endcase
            if (do_fin && !push_o && !quiet) begin
              push_o = 1'b1;
              res_o.record_done = 1'b1;
            end
          end
        end
        M_ADV: begin
          res_o.column = col_q;
          case (rd_cls)
            CLS_NULL, CLS_ZERO, CLS_ONE: begin
              push_o = 1'b1;
              res_o.kind = (rd_cls == CLS_NULL) ? KIND_NULL : KIND_INT;
              res_o.int_value = (rd_cls == CLS_ONE) ? 64'sd1 : 64'sd0;
              res_o.value_done = 1'b1; res_o.record_done = last_col;
            end
            CLS_RSVD: begin
              push_o = 1'b1; res_o.record_done = 1'b1; res_o.error_code = ERR_TRUNC;
              do_fin = 1'b1; fin_end = ended_q;
            end
            default: begin
              if ((rd_cls == CLS_TEXT || rd_cls == CLS_BLOB) && rd_size == '0) begin
                push_o = 1'b1;
                res_o.kind = (rd_cls == CLS_TEXT) ? KIND_TEXT : KIND_BLOB;
                res_o.value_done = 1'b1; res_o.record_done = last_col;
              end else if (({1'b0, rd_size} + {1'b0, bp_q}) > MaxPW || ended_q) begin
                push_o = 1'b1; res_o.record_done = 1'b1; res_o.error_code = ERR_TRUNC;
                do_fin = 1'b1; fin_end = ended_q;
              end else begin
                left_d = rd_size; iacc_d = '0; phase_d = PH_VALUE; mode_d = M_RUN;
              end
            end
          endcase
          if (res_o.value_done) begin
            if (last_col) begin
              do_fin = 1'b1; fin_end = ended_q;
            end else begin
              col_d = col_q + ColIdxW'(1);
            end
          end
        end
        default: begin
          push_o = 1'b1;
          res_o.column = col_q; res_o.record_done = 1'b1; res_o.error_code = ERR_TRUNC;
          do_fin = 1'b1; fin_end = 1'b1;
        end
      endcase
    end

    if (do_fin) begin
      mode_d = M_RUN;
      if (fin_end) begin
        phase_d = PH_HSIZE; bp_d = '0; hl_d = '0; vacc_d = '0; vcnt_d = '0;
        total_d = '0; col_d = '0; left_d = '0; iacc_d = '0;
      end else begin
        phase_d = PH_WAIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HSIZE;
      mode_q  <= M_RUN;
      bp_q    <= '0;
      hl_q    <= '0;
      left_q  <= '0;
      vacc_q  <= '0;
      iacc_q  <= '0;
      vcnt_q  <= '0;
      total_q <= '0;
      col_q   <= '0;
      ended_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      bp_q    <= bp_d;
      hl_q    <= hl_d;
      left_q  <= left_d;
      vacc_q  <= vacc_d;
      iacc_q  <= iacc_d;
      vcnt_q  <= vcnt_d;
      total_q <= total_d;
      col_q   <= col_d;
      ended_q <= ended_d;
    end
  end

endmodule
